### hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared widths, byte positions, checksum and scaling helpers for the
// humidity/temperature reply frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int TEMP_W     = 15;
  localparam int HUMID_W    = 14;
  localparam int TPROD_W    = WORD_W + TEMP_W;
  localparam int HPROD_W    = WORD_W + HUMID_W;
  localparam int DIV_W      = 32;

  // byte position inside a six-byte reply
  typedef logic [2:0] pos_t;
  localparam pos_t POS_TEMP_HI  = 3'd0;
  localparam pos_t POS_TEMP_LO  = 3'd1;
  localparam pos_t POS_TEMP_CRC = 3'd2;
  localparam pos_t POS_HUM_HI   = 3'd3;
  localparam pos_t POS_HUM_LO   = 3'd4;
  localparam pos_t POS_HUM_CRC  = 3'd5;

  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  localparam logic [TEMP_W-1:0]  TEMP_SCALE  = 15'd17500;
  localparam logic [HUMID_W-1:0] HUMID_SCALE = 14'd10000;
  localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 15'd4500;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -15'sd4500;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 15'sd13000;
  localparam logic [HUMID_W-1:0]       HUMID_MAX = 14'd10000;

  // crc-8, msb first, one byte
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 65535 * 65536
  function automatic logic [WORD_W-1:0] div65535(input logic [DIV_W-1:0] x);
    logic [DIV_W-1:0] s;
    s = x + {{WORD_W{1'b0}}, x[DIV_W-1:WORD_W]} + DIV_W'(1);
    return s[DIV_W-1:WORD_W];
  endfunction

endpackage

`default_nettype wire

### hdl/htfd_if.sv
// ----------------------------------------------------------------------------
// htfd_if
// Valid/ready channels of the frame decoder: received bytes in, decoded
// readings out.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [htfd_pkg::BYTE_W-1:0]   rx_byte;
  logic                          frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic signed [htfd_pkg::TEMP_W-1:0]  temp_centideg;
  logic [htfd_pkg::HUMID_W-1:0]        humid_centipct;

  modport source (output valid, status, temp_centideg, humid_centipct, input ready);
  modport sink   (input valid, status, temp_centideg, humid_centipct, output ready);
endinterface

`default_nettype wire

### hdl/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Checks and converts the six-byte reply of a humidity/temperature sensor.
// ----------------------------------------------------------------------------
// Takes one reply byte per cycle unless input is held off. Bytes run
// temperature high, low, crc, humidity high, low, crc; frame_start forces
// the byte to position zero and after the sixth byte the position wraps on
// its own. The sixth byte yields one result once it has passed a word
// register, a product register (one constant multiply per reading) and the
// output register. The output fields are the cached readings: they change
// only when both checksums match, and status is 1 otherwise. Input is held
// off only when all three result registers are full and the output is not
// being taken.
`default_nettype none

module humidity_temp_frame_decoder (
  input  logic              clk,
  input  logic              rst_n,
  htfd_in_if.sink           in_ch,
  htfd_out_if.source        out_ch
);

  // frame tracking
  htfd_pkg::pos_t                   pos_r, pos_nxt, pos_cur;
  logic [htfd_pkg::BYTE_W-1:0]      crc_r, crc_nxt;
  logic [htfd_pkg::WORD_W-1:0]      temp_word_r, temp_word_nxt;
  logic [htfd_pkg::BYTE_W-1:0]      humid_hi_r, humid_hi_nxt;
  logic                             temp_ok_r, temp_ok_nxt;
  logic                             in_xfer, in_final;

  // result pipeline
  logic                             job_v_r, job_ok_r;
  logic [htfd_pkg::WORD_W-1:0]      job_temp_r, job_humid_r;
  logic                             prod_v_r, prod_ok_r;
  logic [htfd_pkg::TPROD_W-1:0]     prod_temp_r;
  logic [htfd_pkg::HPROD_W-1:0]     prod_humid_r;
  logic                             out_valid_r, status_r;
  logic signed [htfd_pkg::TEMP_W-1:0] cached_temp_r;
  logic [htfd_pkg::HUMID_W-1:0]     cached_humid_r;

  logic                             out_free, prod_free, job_free;
  logic                             prod_adv, job_adv;
  logic [htfd_pkg::WORD_W-1:0]      temp_q, humid_q;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign prod_free = !prod_v_r || out_free;
  assign job_free  = !job_v_r || prod_free;
  assign prod_adv  = prod_v_r && out_free;
  assign job_adv   = job_v_r && prod_free;

  assign in_ch.ready = job_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_ch.frame_start || (pos_r > htfd_pkg::POS_HUM_CRC)) begin
      pos_cur = htfd_pkg::POS_TEMP_HI;
    end else begin
      pos_cur = pos_r;
    end
  end

  assign in_final = (pos_cur == htfd_pkg::POS_HUM_CRC);

  always_comb begin
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    humid_hi_nxt  = humid_hi_r;
    temp_ok_nxt   = temp_ok_r;
    pos_nxt       = pos_cur + htfd_pkg::pos_t'(1);
    unique case (pos_cur)
      htfd_pkg::POS_TEMP_HI: begin
        crc_nxt       = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, in_ch.rx_byte);
        temp_word_nxt = {in_ch.rx_byte, temp_word_r[htfd_pkg::BYTE_W-1:0]};
      end
      htfd_pkg::POS_TEMP_LO: begin
        crc_nxt       = htfd_pkg::crc8_byte(crc_r, in_ch.rx_byte);
        temp_word_nxt = {temp_word_r[htfd_pkg::WORD_W-1:htfd_pkg::BYTE_W], in_ch.rx_byte};
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_ok_nxt = (crc_r == in_ch.rx_byte);
        crc_nxt     = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_HUM_HI: begin
        crc_nxt      = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, in_ch.rx_byte);
        humid_hi_nxt = in_ch.rx_byte;
      end
      htfd_pkg::POS_HUM_LO: begin
        crc_nxt = htfd_pkg::crc8_byte(crc_r, in_ch.rx_byte);
      end
      htfd_pkg::POS_HUM_CRC: begin
        crc_nxt = htfd_pkg::CRC_INIT;
        pos_nxt = htfd_pkg::POS_TEMP_HI;
      end
      default: begin
        pos_nxt = htfd_pkg::POS_TEMP_HI;
      end
    endcase
  end

  // humidity low byte is only needed at the final byte, when it sits in the job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= htfd_pkg::POS_TEMP_HI;
      crc_r     <= htfd_pkg::CRC_INIT;
      temp_ok_r <= 1'b0;
    end else if (in_xfer) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      temp_ok_r <= temp_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      temp_word_r <= temp_word_nxt;
      humid_hi_r  <= humid_hi_nxt;
    end
  end

  logic [htfd_pkg::BYTE_W-1:0] humid_lo_r;
  always_ff @(posedge clk) begin
    if (in_xfer && (pos_cur == htfd_pkg::POS_HUM_LO)) begin
      humid_lo_r <= in_ch.rx_byte;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
    end else if (job_free) begin
      job_v_r <= in_xfer && in_final;
    end
  end

  always_ff @(posedge clk) begin
    if (job_free && in_xfer && in_final) begin
      job_ok_r    <= temp_ok_r && (crc_r == in_ch.rx_byte);
      job_temp_r  <= temp_word_r;
      job_humid_r <= {humid_hi_r, humid_lo_r};
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (prod_free) begin
      prod_v_r <= job_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (job_adv) begin
      prod_ok_r    <= job_ok_r;
      prod_temp_r  <= htfd_pkg::TPROD_W'(job_temp_r) * htfd_pkg::TPROD_W'(htfd_pkg::TEMP_SCALE);
      prod_humid_r <= htfd_pkg::HPROD_W'(job_humid_r) * htfd_pkg::HPROD_W'(htfd_pkg::HUMID_SCALE);
    end
  end

  // divide by full scale, then offset
  assign temp_q  = htfd_pkg::div65535(htfd_pkg::DIV_W'(prod_temp_r));
  assign humid_q = htfd_pkg::div65535(htfd_pkg::DIV_W'(prod_humid_r));

  // output register; the cache doubles as the result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      status_r       <= 1'b0;
      cached_temp_r  <= '0;
      cached_humid_r <= '0;
    end else begin
      if (out_free) begin
        out_valid_r <= prod_v_r;
      end
      if (prod_adv) begin
        status_r <= !prod_ok_r;
        if (prod_ok_r) begin
          cached_temp_r  <= htfd_pkg::TEMP_W'(temp_q) - htfd_pkg::TEMP_OFFSET;
          cached_humid_r <= htfd_pkg::HUMID_W'(humid_q);
        end
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.temp_centideg  = cached_temp_r;
  assign out_ch.humid_centipct = cached_humid_r;

`ifndef SYNTHESIS
  a_final_makes_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_final) |=> job_v_r)
    else $error("final byte did not enter the word register");

  a_cache_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !prod_adv |=> ($stable(cached_temp_r) && $stable(cached_humid_r)))
    else $error("cached readings changed without a result load");

  a_prod_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_v_r && !out_free) |=> (prod_v_r && $stable(prod_temp_r) && $stable(prod_humid_r)))
    else $error("product register lost data while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= htfd_pkg::POS_HUM_CRC)
    else $error("byte position out of range");

  a_reading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !status_r) |->
      (cached_temp_r >= htfd_pkg::TEMP_MIN && cached_temp_r <= htfd_pkg::TEMP_MAX &&
       cached_humid_r <= htfd_pkg::HUMID_MAX))
    else $error("converted reading out of range");
`endif

endmodule

`default_nettype wire
